// ===== hdl/lfu_pkg.sv =====
// shared constants and codes for the lfu cache
package lfu_pkg;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;
endpackage

// ===== hdl/lfu_if.sv =====
// valid/ready channel interfaces for requests and results
interface lfu_in_if;
  import lfu_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [KEY_W-1:0]  key;
  logic signed [VAL_W-1:0] write_value;
  modport source (output valid, cmd, key, write_value, input ready);
  modport sink (input valid, cmd, key, write_value, output ready);
endinterface

interface lfu_out_if;
  import lfu_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic signed [VAL_W-1:0] read_value;
  modport source (output valid, hit, read_value, input ready);
  modport sink (input valid, hit, read_value, output ready);
endinterface

// ===== hdl/lfu_ram.sv =====
// generic single-port-write ram with registered read
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic [AW-1:0]           raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/lfu_cache_with_lru_tiebreak.sv =====
// top level of the lfu cache with lru tie-break
// a get answers from the decision step after its scan pass, once the output register is free
// the next beat is taken only back in idle: after the scan pass for a get miss or an ignored put (plus result stalls),
// after a further rank pass for a hit or a resident put, and after the insert step as well for an insert
// one request at a time, set by the single ram read port: one scan pass, then at most one rank pass
// reset (sync, rst_n low) clears valid bits, resident count, capacity to 16
module lfu_cache_with_lru_tiebreak import lfu_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  lfu_in_if.sink           in_ch,
  lfu_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);
  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW  = IW;                     // recency rank width
  localparam int RCW = $clog2(ENTRIES + 1);    // resident count width

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      data;
    logic [COUNT_BITS-1:0] cnt;
    logic [RW-1:0]         rank;
  } ent_t;

  localparam int EW = $bits(ent_t);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_PASS, ST_INS
  } state_t;

  state_t              state_r;
  logic [IW:0]         cnt_r;        // read issue counter
  logic                rd_pend_r;    // ram data valid this cycle
  logic [IW-1:0]       rd_idx_r;
  logic [CAP_W-1:0]    cap_r;
  logic [RCW-1:0]      resident_r;
  logic [ENTRIES-1:0]  valid_r;

  // request held for the whole sequence
  logic                cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    wval_r;

  // scan results
  logic                hit_r;
  logic [IW-1:0]       hidx_r;
  logic [RW-1:0]       hrank_r;
  logic [VAL_W-1:0]    hdata_r;
  logic                vfound_r;
  logic [IW-1:0]       vidx_r;
  logic [COUNT_BITS-1:0] vcnt_r;
  logic [RW-1:0]       vrank_r;
  logic                ffound_r;
  logic [IW-1:0]       fidx_r;

  // rank pass mode
  logic                ins_mode_r;   // 1: insert pass, 0: touch pass
  logic                evicted_r;
  logic [IW-1:0]       islot_r;

  logic                out_valid_r;
  logic                out_hit_r;
  logic [VAL_W-1:0]    out_val_r;

  // ram ports
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  ent_t                ram_wdata;
  ent_t                ram_rdata;
  logic [EW-1:0]       ram_rbits;

  lfu_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (ram_rbits)
  );
  assign ram_rdata = ent_t'(ram_rbits);

  // effective capacity and occupancy checks
  logic        cap_zero;
  logic        full;
  logic [31:0] cap_eff;
  assign cap_zero = (cap_r == '0);
  assign cap_eff  = (32'(cap_r) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(cap_r);
  assign full     = (32'(resident_r) >= cap_eff);

  logic issue_done;
  assign issue_done = (cnt_r == (IW+1)'(ENTRIES));

  logic rd_ev;     // entry under the read pointer is resident
  assign rd_ev = valid_r[rd_idx_r];

  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  // a get result is loaded into the output register this cycle
  logic out_load;
  assign out_load = (state_r == ST_DECIDE) && (cmd_r == CMD_GET) && out_free;

  // miss decision for a put
  logic          do_evict;
  logic [IW-1:0] ins_slot;
  logic          ins_ok;
  always_comb begin
    do_evict = full && vfound_r;
    ins_ok   = do_evict || ffound_r;
    if (do_evict && (!ffound_r || vidx_r < fidx_r)) begin
      ins_slot = vidx_r;
    end else begin
      ins_slot = fidx_r;
    end
  end

  // write-back data for the rank pass and the final insert
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx_r;
    ram_wdata = ram_rdata;
    case (state_r)
      ST_PASS: begin
        ram_we = rd_pend_r && rd_ev;
        if (ins_mode_r) begin
          if (evicted_r && ram_rdata.rank > vrank_r) begin
            ram_wdata.rank = ram_rdata.rank;       // minus one, plus one
          end else begin
            ram_wdata.rank = ram_rdata.rank + 1'b1;
          end
        end else if (rd_idx_r == hidx_r) begin
          ram_wdata.rank = '0;
          if (ram_rdata.cnt != '1) begin
            ram_wdata.cnt = ram_rdata.cnt + 1'b1;
          end
          if (cmd_r == CMD_PUT) begin
            ram_wdata.data = wval_r;
          end
        end else if (ram_rdata.rank < hrank_r) begin
          ram_wdata.rank = ram_rdata.rank + 1'b1;
        end
      end
      ST_INS: begin
        ram_we         = 1'b1;
        ram_waddr      = islot_r;
        ram_wdata.key  = key_r;
        ram_wdata.data = wval_r;
        ram_wdata.cnt  = COUNT_BITS'(1);
        ram_wdata.rank = '0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      cap_r       <= CAP_RESET;
      resident_r  <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      rd_idx_r  <= cnt_r[IW-1:0];

      case (state_r)
        ST_IDLE: begin
          cnt_r     <= '0;
          rd_pend_r <= 1'b0;
          if (in_ch.valid) begin
            cmd_r    <= in_ch.cmd;
            key_r    <= in_ch.key;
            wval_r   <= in_ch.write_value;
            hit_r    <= 1'b0;
            vfound_r <= 1'b0;
            ffound_r <= 1'b0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_pend_r <= !issue_done;
          if (!issue_done) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (rd_pend_r) begin
            if (rd_ev && !hit_r && ram_rdata.key == key_r) begin
              hit_r   <= 1'b1;
              hidx_r  <= rd_idx_r;
              hrank_r <= ram_rdata.rank;
              hdata_r <= ram_rdata.data;
            end
            if (rd_ev && (!vfound_r || ram_rdata.cnt < vcnt_r ||
                (ram_rdata.cnt == vcnt_r && ram_rdata.rank > vrank_r))) begin
              vfound_r <= 1'b1;
              vidx_r   <= rd_idx_r;
              vcnt_r   <= ram_rdata.cnt;
              vrank_r  <= ram_rdata.rank;
            end
            if (!rd_ev && !ffound_r) begin
              ffound_r <= 1'b1;
              fidx_r   <= rd_idx_r;
            end
          end else if (issue_done) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          cnt_r      <= '0;
          rd_pend_r  <= 1'b0;
          ins_mode_r <= 1'b0;
          evicted_r  <= 1'b0;
          if (cmd_r == CMD_GET) begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_hit_r   <= hit_r;
              out_val_r   <= hit_r ? hdata_r : '0;
              state_r     <= hit_r ? ST_PASS : ST_IDLE;
            end
          end else if (cap_zero) begin
            state_r <= ST_IDLE;
          end else if (hit_r) begin
            state_r <= ST_PASS;
          end else begin
            // eviction drops the victim's valid bit before the rank pass
            if (do_evict) begin
              valid_r[vidx_r] <= 1'b0;
              resident_r      <= resident_r - 1'b1;
            end
            evicted_r  <= do_evict;
            ins_mode_r <= 1'b1;
            islot_r    <= ins_slot;
            state_r    <= ins_ok ? ST_PASS : ST_IDLE;
          end
        end
        ST_PASS: begin
          rd_pend_r <= !issue_done;
          if (!issue_done) begin
            cnt_r <= cnt_r + 1'b1;
          end else if (!rd_pend_r) begin
            state_r <= ins_mode_r ? ST_INS : ST_IDLE;
          end
        end
        ST_INS: begin
          rd_pend_r        <= 1'b0;
          valid_r[islot_r] <= 1'b1;
          resident_r       <= resident_r + 1'b1;
          state_r          <= ST_IDLE;
        end
        default: begin
          rd_pend_r <= 1'b0;
          state_r   <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.read_value = out_val_r;

  // resident count tracks the valid bits exactly
  a_resident_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(resident_r))
    else $error("resident count out of step with valid bits");

  // a get leaving the decision step always has its result registered
  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && cmd_r == CMD_GET && out_free) |=> out_valid_r)
    else $error("get finished without a result");

  // an insert writes a slot that is not resident
  a_ins_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |-> !valid_r[islot_r])
    else $error("insert into a resident slot");
endmodule
